>>> src/nltc_pkg.sv
// Shared types, constants and character-class functions for the literal classifier.
package nltc_pkg;

    localparam int unsigned PosW = 3;
    localparam int unsigned HexW = 33;
    localparam logic [PosW-1:0] PosMax = PosW'(6);
    localparam logic [HexW-1:0] HexSat = {HexW{1'b1}};
    localparam logic [HexW-1:0] HexLimit = HexW'(64'h8000_0000);

    typedef enum logic [3:0] {
        TC_BOOLEAN = 4'd0,
        TC_INT     = 4'd1,
        TC_BYTE    = 4'd2,
        TC_CHAR    = 4'd3,
        TC_SHORT   = 4'd4,
        TC_FLOAT   = 4'd5,
        TC_DOUBLE  = 4'd6,
        TC_LONG    = 4'd7,
        TC_QUAD    = 4'd8,
        TC_UNKNOWN = 4'd9
    } t_type_code;

    typedef struct packed {
        logic               only_sign_digit;
        logic               only_base_chars;
        logic [7:0]         foreign_letter;
        logic               foreign_seen;
        logic               foreign_multiple;
        logic [PosW-1:0]    position;
        logic [1:0]         word_match;
        logic               hex_chars_ok;
        logic               hex_prefix_ok;
        logic               hex_digits_running;
        logic [HexW-1:0]    hex_value;
    } t_track;

    localparam t_track TrackReset = '{
        only_sign_digit:    1'b1,
        only_base_chars:    1'b1,
        foreign_letter:     8'h00,
        foreign_seen:       1'b0,
        foreign_multiple:   1'b0,
        position:           '0,
        word_match:         2'b11,
        hex_chars_ok:       1'b1,
        hex_prefix_ok:      1'b1,
        hex_digits_running: 1'b1,
        hex_value:          '0
    };

    function automatic logic is_sign_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || c == "+" || c == "-";
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return is_sign_digit(c) || c == "." || c == "e";
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0: r = "t";
            2'd1: r = "r";
            2'd2: r = "u";
            default: r = "e";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] false_char(input logic [PosW-1:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = "f";
            3'd1: r = "a";
            3'd2: r = "l";
            3'd3: r = "s";
            3'd4: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> src/nltc_track.sv
// Per-token running flags, word matcher, hex prefix check and saturating hex value.
module nltc_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    output nltc_pkg::t_track     o_next,
    output logic [nltc_pkg::PosW-1:0] o_pos
);
    import nltc_pkg::*;

    t_track r_st;
    t_track n_st;
    logic   sd;
    logic   base;
    logic   hd_ok;
    logic   hexc;
    logic [PosW-1:0] p;

    assign p     = r_st.position;
    assign sd    = is_sign_digit(i_ch);
    assign base  = is_base(i_ch);
    assign hd_ok = is_hex_digit(i_ch);
    assign hexc  = sd || i_ch == "x" || hd_ok;

    always_comb begin
        n_st = r_st;
        if (!sd) n_st.only_sign_digit = 1'b0;
        if (!base) begin
            n_st.only_base_chars = 1'b0;
            if (!r_st.foreign_seen) begin
                n_st.foreign_seen   = 1'b1;
                n_st.foreign_letter = i_ch;
            end else if (r_st.foreign_letter != i_ch) begin
                n_st.foreign_multiple = 1'b1;
            end
        end
        if (!hexc) n_st.hex_chars_ok = 1'b0;

        if (p >= PosW'(4) || i_ch != true_char(p[1:0])) n_st.word_match[0] = 1'b0;
        if (p >= PosW'(5) || i_ch != false_char(p)) n_st.word_match[1] = 1'b0;

        if (p == PosW'(0) && i_ch != "0") n_st.hex_prefix_ok = 1'b0;
        if (p == PosW'(1) && i_ch != "x") n_st.hex_prefix_ok = 1'b0;

        if (p >= PosW'(2) && r_st.hex_digits_running) begin
            if (hd_ok) begin
                if (r_st.hex_value[HexW-1:HexW-4] != 4'd0) begin
                    n_st.hex_value = HexSat;
                end else begin
                    n_st.hex_value = {r_st.hex_value[HexW-5:0], hex_nibble(i_ch)};
                end
            end else begin
                n_st.hex_digits_running = 1'b0;
            end
        end

        if (p < PosMax) n_st.position = p + PosW'(1);
    end

    assign o_next = n_st;
    assign o_pos  = p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= TrackReset;
        end else if (i_step) begin
            r_st <= i_last ? TrackReset : n_st;
        end
    end

endmodule

>>> src/nltc_decide.sv
// Priority classification of a finished token from its updated flags.
module nltc_decide (
    input  logic [7:0]                 i_ch,
    input  nltc_pkg::t_track           i_st,
    input  logic [nltc_pkg::PosW-1:0]  i_pos,
    output nltc_pkg::t_type_code       o_code,
    output logic                       o_strip
);
    import nltc_pkg::*;

    logic       sc_ok;
    logic       sc_strip;
    t_type_code sc_code;

    always_comb begin
        sc_ok    = 1'b1;
        sc_strip = 1'b1;
        sc_code  = TC_UNKNOWN;
        case (i_ch)
            "b", "B": sc_code = TC_BYTE;
            "c", "C": sc_code = TC_CHAR;
            "i", "I": sc_code = TC_INT;
            "s", "S": sc_code = TC_SHORT;
            "f", "F": begin sc_code = TC_FLOAT; sc_strip = 1'b0; end
            "d", "D": sc_code = TC_DOUBLE;
            "l", "L": begin sc_code = TC_LONG; sc_strip = 1'b0; end
            default: begin sc_ok = 1'b0; sc_strip = 1'b0; end
        endcase
    end

    always_comb begin
        o_strip = 1'b0;
        if ((i_st.word_match[0] && i_pos == PosW'(3)) ||
            (i_st.word_match[1] && i_pos == PosW'(4))) begin
            o_code = TC_BOOLEAN;
        end else if (i_st.only_sign_digit) begin
            o_code = TC_INT;
        end else if (sc_ok && i_st.foreign_seen && !i_st.foreign_multiple &&
                     i_st.foreign_letter == i_ch) begin
            o_code  = sc_code;
            o_strip = sc_strip;
        end else if (i_st.only_base_chars) begin
            o_code = TC_QUAD;
        end else if (i_pos >= PosW'(2) && i_st.hex_prefix_ok && i_st.hex_chars_ok) begin
            o_code = (i_st.hex_value > HexLimit) ? TC_LONG : TC_INT;
        end else begin
            o_code = TC_UNKNOWN;
        end
    end

endmodule

>>> src/numeric_literal_type_classifier.sv
// Top level: input register, per-character tracker, classifier and result register.
// One character is accepted per cycle while nothing stalls; each character waits in
// the input register, where the tracker updates the token flags, and the final
// character's type code is then captured in the result register. Non-final characters
// give no result. The input register keeps taking characters while a result waits;
// only a final character stalls, when the result register is still full.
module numeric_literal_type_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_type_code,
    output logic       o_suffix_stripped
);
    import nltc_pkg::*;

    logic            r_in_valid;
    logic [7:0]      r_ch;
    logic            r_last;
    logic            r_out_valid;
    logic [3:0]      r_code;
    logic            r_strip;
    logic            fire;
    t_track          st_next;
    logic [PosW-1:0] pos;
    t_type_code      code;
    logic            strip;

    assign fire    = r_in_valid && (!r_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    nltc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_ch    (r_ch),
        .i_last  (r_last),
        .o_next  (st_next),
        .o_pos   (pos)
    );

    nltc_decide u_decide (
        .i_ch    (r_ch),
        .i_st    (st_next),
        .i_pos   (pos),
        .o_code  (code),
        .o_strip (strip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_last) begin
            r_code  <= code;
            r_strip <= strip;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_type_code       = r_code;
    assign o_suffix_stripped = r_strip;

endmodule

>>> dv/numeric_literal_type_classifier_tb.sv
// Testbench for the literal classifier: token stimulus, flag-based prediction, result checks.
module numeric_literal_type_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nltc_pkg::*;

    localparam int unsigned RandChars = 650;
    localparam int unsigned CycleLimit = 200000;
    localparam logic [36:0] ValueSat = 37'h1_FFFF_FFFF;
    localparam logic [32:0] LongAbove = 33'h0_8000_0000;

    typedef struct packed {
        t_type_code code;
        logic       strip;
    } t_lit_result;

    typedef struct {
        string      tok;
        logic [7:0] raw;
        bit         typed;
        t_type_code code;
        logic       strip;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_ch = 8'h00;
    logic       i_last = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_type_code;
    logic       o_suffix_stripped;

    // token tracking state of the predictor
    logic        sd_only, base_only, f_seen, f_multi, hx_chars, hx_pfx, hx_run;
    logic [7:0]  f_char;
    logic [2:0]  pos;
    logic [1:0]  word_alive;
    logic [32:0] hx_val;

    t_lit_result pending_types[$];
    logic [7:0]  tok_q[$];
    t_dir_row    dir_rows[15];
    bit          codes_seen[10];
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int unsigned n_chars = 0;
    int unsigned n_tokens = 0;
    int unsigned n_results = 0;
    int unsigned n_err = 0;
    int unsigned cycle_cnt = 0;

    numeric_literal_type_classifier dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_ch              (i_ch),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_type_code       (o_type_code),
        .o_suffix_stripped (o_suffix_stripped)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("%0t: timeout, %0d results still expected", $time, pending_types.size());
            $display("numeric_literal_type_classifier: mismatch");
            $finish;
        end
    end

    function automatic void clear_token();
        sd_only    = 1'b1;
        base_only  = 1'b1;
        f_char     = 8'h00;
        f_seen     = 1'b0;
        f_multi    = 1'b0;
        pos        = 3'd0;
        word_alive = 2'b11;
        hx_chars   = 1'b1;
        hx_pfx     = 1'b1;
        hx_run     = 1'b1;
        hx_val     = '0;
    endfunction

    // Steps the token state by one character; returns 1 with the type on the final one.
    function automatic bit classify_char(input logic [7:0] c, input bit lst,
                                         output t_lit_result res);
        logic [2:0]  p;
        logic        is_sd, is_base, is_hd, is_hex, sc_ok;
        logic [3:0]  nib;
        logic [36:0] grown;
        logic [7:0]  tw, fw;
        t_lit_result sc;
        p = pos;
        is_sd = (c >= "0" && c <= "9") || c == "+" || c == "-";
        is_base = is_sd || c == "." || c == "e";
        is_hd = 1'b1;
        nib = 4'd0;
        if (c >= "0" && c <= "9") begin
            nib = 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            nib = 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            nib = 4'(c - 8'h37);
        end else begin
            is_hd = 1'b0;
        end
        is_hex = is_sd || c == "x" || is_hd;

        if (!is_sd) sd_only = 1'b0;
        if (!is_base) begin
            base_only = 1'b0;
            if (!f_seen) begin
                f_seen = 1'b1;
                f_char = c;
            end else if (f_char != c) begin
                f_multi = 1'b1;
            end
        end
        if (!is_hex) hx_chars = 1'b0;

        case (p)
            3'd0: begin tw = "t"; fw = "f"; end
            3'd1: begin tw = "r"; fw = "a"; end
            3'd2: begin tw = "u"; fw = "l"; end
            3'd3: begin tw = "e"; fw = "s"; end
            default: begin tw = 8'h00; fw = "e"; end
        endcase
        if (p >= 4 || c != tw) word_alive[0] = 1'b0;
        if (p >= 5 || c != fw) word_alive[1] = 1'b0;

        if (p == 0 && c != "0") hx_pfx = 1'b0;
        if (p == 1 && c != "x") hx_pfx = 1'b0;

        if (p >= 2 && hx_run) begin
            if (is_hd) begin
                grown = {hx_val, 4'h0} + 37'(nib);
                hx_val = (grown > ValueSat) ? ValueSat[32:0] : grown[32:0];
            end else begin
                hx_run = 1'b0;
            end
        end

        if (pos < 3'd6) pos = pos + 3'd1;

        res = '{code: TC_UNKNOWN, strip: 1'b0};
        if (!lst) return 1'b0;

        sc_ok = 1'b1;
        case (c)
            "b", "B": sc = '{code: TC_BYTE,   strip: 1'b1};
            "c", "C": sc = '{code: TC_CHAR,   strip: 1'b1};
            "i", "I": sc = '{code: TC_INT,    strip: 1'b1};
            "s", "S": sc = '{code: TC_SHORT,  strip: 1'b1};
            "f", "F": sc = '{code: TC_FLOAT,  strip: 1'b0};
            "d", "D": sc = '{code: TC_DOUBLE, strip: 1'b1};
            "l", "L": sc = '{code: TC_LONG,   strip: 1'b0};
            default: begin
                sc = '{code: TC_UNKNOWN, strip: 1'b0};
                sc_ok = 1'b0;
            end
        endcase

        if ((word_alive[0] && p == 3) || (word_alive[1] && p == 4)) begin
            res.code = TC_BOOLEAN;
        end else if (sd_only) begin
            res.code = TC_INT;
        end else if (sc_ok && f_seen && !f_multi && f_char == c) begin
            res = sc;
        end else if (base_only) begin
            res.code = TC_QUAD;
        end else if (p >= 2 && hx_pfx && hx_chars) begin
            res.code = (hx_val > LongAbove) ? TC_LONG : TC_INT;
        end
        clear_token();
        return 1'b1;
    endfunction

    function automatic void check_result(input logic [3:0] tc, input logic ss);
        t_lit_result want;
        if (pending_types.size() == 0) begin
            $display("%0t: unexpected result, type_code %0d suffix_stripped %0d",
                     $time, tc, ss);
            n_err++;
            return;
        end
        want = pending_types.pop_front();
        n_results++;
        codes_seen[int'(want.code)] = 1'b1;
        if (tc !== want.code) begin
            $display("%0t: type_code expected %0d got %0d", $time, want.code, tc);
            n_err++;
        end
        if (ss !== want.strip) begin
            $display("%0t: suffix_stripped expected %0d got %0d", $time, want.strip, ss);
            n_err++;
        end
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1, 0)];
    endfunction

    function automatic void make_token();
        int unsigned kind, n;
        logic [7:0]  sfx;
        logic [32:0] v;
        logic [3:0]  nib;
        string       w;
        tok_q.delete();
        kind = $urandom_range(99, 0);
        if (kind < 15) begin
            if ($urandom_range(2, 0) == 0) tok_q.push_back(pick("+-"));
            n = $urandom_range(6, 1);
            repeat (n) tok_q.push_back(pick("0123456789"));
        end else if (kind < 40) begin
            sfx = pick("bBcCiIsSfFdDlL");
            n = $urandom_range(4, 0);
            repeat (n) begin
                tok_q.push_back(($urandom_range(5, 0) == 0) ? sfx : pick("+-0123456789.e"));
            end
            if ($urandom_range(9, 0) == 0) tok_q.push_back(pick("bBcCiIsSfFdDlLxg"));
            tok_q.push_back(sfx);
        end else if (kind < 50) begin
            n = $urandom_range(6, 1);
            repeat (n) tok_q.push_back(pick("+-0123456789.e"));
        end else if (kind < 60) begin
            if ($urandom_range(1, 0) == 1) begin
                w = "true";
            end else begin
                w = "false";
            end
            for (int i = 0; i < w.len(); i++) tok_q.push_back(w[i]);
            if ($urandom_range(2, 0) == 0) begin
                case ($urandom_range(2, 0))
                    0: void'(tok_q.pop_back());
                    1: tok_q.push_back(pick("eslx0"));
                    default: tok_q[$urandom_range(tok_q.size() - 1, 0)] = pick("aeflrstuTF");
                endcase
            end
        end else if (kind < 85) begin
            if ($urandom_range(9, 0) == 0) begin
                tok_q.push_back(pick("01x"));
                tok_q.push_back(pick("xX0"));
            end else begin
                tok_q.push_back("0");
                tok_q.push_back("x");
            end
            if ($urandom_range(4, 0) == 0) begin
                // around the int/long boundary
                v = 33'h0_7FFF_FFFF + 33'($urandom_range(2, 0));
                for (int i = 7; i >= 0; i--) begin
                    nib = v[i*4 +: 4];
                    if (nib < 4'd10) begin
                        tok_q.push_back(8'h30 + 8'(nib));
                    end else begin
                        tok_q.push_back((($urandom_range(1, 0) == 1) ? 8'h57 : 8'h37)
                                        + 8'(nib));
                    end
                end
            end else begin
                n = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 0);
                repeat (n) tok_q.push_back(pick("0123456789abcdefABCDEF"));
            end
            if ($urandom_range(5, 0) == 0) begin
                tok_q.push_back(pick("x+-"));
                if ($urandom_range(1, 0) == 1) tok_q.push_back(pick("0123456789aF"));
            end
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) tok_q.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input bit lst, input bit typed,
                             input t_lit_result typed_res);
        int unsigned gap;
        logic        rdy;
        bit          got;
        t_lit_result pred;
        gap = send_burst ? 0 : $urandom_range(17, 0);
        if ($urandom_range(39, 0) == 0) send_burst = !send_burst;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_last <= lst;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (rdy !== 1'b1);
        n_chars++;
        got = classify_char(c, lst, pred);
        if (got) pending_types.push_back(typed ? typed_res : pred);
    endtask

    task automatic send_token(input bit typed, input t_lit_result typed_res);
        for (int i = 0; i < tok_q.size(); i++) begin
            send_char(tok_q[i], i == tok_q.size() - 1, typed, typed_res);
        end
        n_tokens++;
    endtask

    initial begin : result_side
        int unsigned stall;
        logic        v;
        logic [3:0]  tc;
        logic        ss;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(17, 0);
            if ($urandom_range(39, 0) == 0) recv_burst = !recv_burst;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                v = o_valid;
                tc = o_type_code;
                ss = o_suffix_stripped;
                @(posedge i_clk);
            end while (v !== 1'b1);
            check_result(tc, ss);
        end
    end

    initial begin : item_side
        int unsigned dir_chars;
        int unsigned n_codes;
        t_lit_result row_res;
        t_lit_result none_res;
        none_res = '{code: TC_UNKNOWN, strip: 1'b0};
        dir_rows = '{
            '{"true",        8'h00, 1'b1, TC_BOOLEAN, 1'b0},
            '{"false",       8'h00, 1'b1, TC_BOOLEAN, 1'b0},
            '{"-9",          8'h00, 1'b0, TC_INT,     1'b0},
            '{"3I",          8'h00, 1'b0, TC_INT,     1'b0},
            '{"1c",          8'h00, 1'b0, TC_INT,     1'b0},
            '{"2S",          8'h00, 1'b0, TC_INT,     1'b0},
            '{".5f",         8'h00, 1'b0, TC_INT,     1'b0},
            '{"1d",          8'h00, 1'b0, TC_INT,     1'b0},
            '{"9L",          8'h00, 1'b0, TC_INT,     1'b0},
            '{".",           8'h00, 1'b0, TC_INT,     1'b0},
            '{"0xA",         8'h00, 1'b0, TC_INT,     1'b0},
            '{"1bb",         8'h00, 1'b0, TC_INT,     1'b0},
            '{"",            8'h00, 1'b1, TC_UNKNOWN, 1'b0},
            '{"",            8'hFF, 1'b1, TC_UNKNOWN, 1'b0},
            '{"0xFFFFFFFFF", 8'h00, 1'b1, TC_LONG,    1'b0}
        };
        clear_token();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            tok_q.delete();
            if (dir_rows[r].tok.len() == 0) begin
                tok_q.push_back(dir_rows[r].raw);
            end else begin
                for (int i = 0; i < dir_rows[r].tok.len(); i++) begin
                    tok_q.push_back(dir_rows[r].tok[i]);
                end
            end
            row_res = '{code: dir_rows[r].code, strip: dir_rows[r].strip};
            send_token(dir_rows[r].typed, row_res);
        end
        dir_chars = n_chars;

        while (n_chars < dir_chars + RandChars) begin
            make_token();
            send_token(1'b0, none_res);
        end
        i_valid <= 1'b0;
        i_last <= 1'b0;

        while (pending_types.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        n_codes = 0;
        foreach (codes_seen[k]) if (codes_seen[k]) n_codes++;
        $display("%0d characters in %0d tokens, %0d classifications checked", n_chars,
                 n_tokens, n_results);
        $display("%0d of 10 type codes produced, %0d errors", n_codes, n_err);
        if (n_err == 0) begin
            $display("numeric_literal_type_classifier: match");
        end else begin
            $display("numeric_literal_type_classifier: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
src/nltc_pkg.sv
src/nltc_track.sv
src/nltc_decide.sv
src/numeric_literal_type_classifier.sv
dv/numeric_literal_type_classifier_tb.sv
